/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled during reset.
`define NMSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same check sampled only on cycles where the result channel shows a request.
`define NMSC_ASSERT_OUT(label, prop, msg) \
    `NMSC_ASSERT(label, m_tvalid |-> (prop), msg)

`endif

/* hdl/nmsc_pkg.sv */
// Shared types and constants of the NMEA sentence checker.
package nmsc_pkg;

    localparam int MAX_FIELDS_DEFAULT = 32;

    localparam logic [7:0] CHAR_DOLLAR = "$";
    localparam logic [7:0] CHAR_G      = "G";
    localparam logic [7:0] CHAR_P      = "P";
    localparam logic [7:0] CHAR_STAR   = "*";
    localparam logic [7:0] CHAR_COMMA  = ",";

    localparam logic [23:0] TYPE_RMC = "RMC";
    localparam logic [23:0] TYPE_GGA = "GGA";
    localparam logic [23:0] TYPE_GSV = "GSV";
    localparam logic [23:0] TYPE_GSA = "GSA";
    localparam logic [23:0] TYPE_XDR = "XDR";
    localparam logic [23:0] TYPE_CAL = "CAL";

    typedef enum logic [1:0] {
        CLS_PREFIX = 2'd0,
        CLS_FIELD  = 2'd1,
        CLS_COMMA  = 2'd2,
        CLS_STAR   = 2'd3
    } byte_class_t;

    typedef enum logic [2:0] {
        VERD_OK_UNCHECKED = 3'd0,
        VERD_OK_CHECKED   = 3'd1,
        VERD_BAD_PREFIX   = 3'd2,
        VERD_MISMATCH     = 3'd3,
        VERD_TOO_MANY     = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_RMC   = 3'd1,
        KIND_GGA   = 3'd2,
        KIND_GSV   = 3'd3,
        KIND_GSA   = 3'd4,
        KIND_XDR   = 3'd5,
        KIND_CAL   = 3'd6
    } sentence_kind_t;

    typedef enum logic [1:0] {
        PFX_PENDING  = 2'd0,
        PFX_GP       = 2'd1,
        PFX_P        = 2'd2,
        PFX_REJECTED = 2'd3
    } prefix_state_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_in_line;
    } item_t;

    typedef struct packed {
        logic [7:0]     echo_byte;
        byte_class_t    byte_class;
        logic [4:0]     field_number;
        logic           line_done;
        verdict_t       verdict;
        sentence_kind_t sentence_kind;
        logic [5:0]     fields_seen;
        logic [7:0]     computed_sum;
        logic [7:0]     received_sum;
    } result_t;

endpackage

/* hdl/nmsc_in_stage.sv */
// Input register of the sentence checker: holds one request for the core.
module nmsc_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          advance,
    output logic          item_valid,
    output nmsc_pkg::item_t item
);
    import nmsc_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    // Take a new request when empty or when the held one moves on.
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                item_next.line_byte    = s_tdata;
                item_next.last_in_line = s_tlast;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/nmsc_core.sv */
// Per-line parse state and the single-pass byte update of the sentence checker.
module nmsc_core #(
    parameter int MAX_FIELDS = nmsc_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  nmsc_pkg::item_t   item,
    output nmsc_pkg::result_t result
);
    import nmsc_pkg::*;

    localparam int FCW      = $clog2(MAX_FIELDS + 1);
    localparam int TAG_MAX  = (MAX_FIELDS - 1 > 31) ? 31 : MAX_FIELDS - 1;
    localparam int SEEN_MAX = (MAX_FIELDS > 63) ? 63 : MAX_FIELDS;

    logic [1:0]     pos_reg, pos_next;
    prefix_state_t  prefix_reg, prefix_next;
    logic [7:0]     xor_reg, xor_next;
    logic           star_reg, star_next;
    logic [7:0]     hex_reg, hex_next;
    logic           hexovf_reg, hexovf_next;
    logic           hexstop_reg, hexstop_next;
    logic [FCW-1:0] fcnt_reg, fcnt_next;
    logic [23:0]    ttext_reg, ttext_next;
    logic [2:0]     tlen_reg, tlen_next;

    logic [7:0]     b;
    logic           accepted;
    logic           hex_ok;
    logic [3:0]     hex_d;
    logic [4:0]     tag;
    logic [FCW:0]   seen_wide;
    sentence_kind_t kind;
    result_t        res;

    assign b = item.line_byte;

    // Prefix recognizer: next state.
    always_comb begin
        prefix_next = prefix_reg;
        unique case (prefix_reg) inside
            PFX_PENDING: begin
                if (!star_reg) begin
                    if (b == CHAR_STAR) begin
                        prefix_next = PFX_REJECTED;
                    end else begin
                        case (pos_reg)
                            2'd0: if (b != CHAR_DOLLAR) prefix_next = PFX_REJECTED;
                            2'd1: begin
                                if (b == CHAR_P) prefix_next = PFX_P;
                                else if (b != CHAR_G) prefix_next = PFX_REJECTED;
                            end
                            default: prefix_next = (b == CHAR_P) ? PFX_GP : PFX_REJECTED;
                        endcase
                    end
                end
            end
            PFX_GP, PFX_P, PFX_REJECTED: prefix_next = prefix_reg;
        endcase
    end

    // Prefix recognizer: output.
    assign accepted = (prefix_reg == PFX_GP) || (prefix_reg == PFX_P);

    // Decode one hex digit, either case.
    always_comb begin
        hex_ok = 1'b0;
        hex_d  = b[3:0];
        if (b >= "0" && b <= "9") begin
            hex_ok = 1'b1;
        end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            hex_ok = 1'b1;
            hex_d  = 4'(b[3:0] + 4'd9);
        end
    end

    // Field tag of the current byte, saturated.
    assign tag = (fcnt_reg > FCW'(TAG_MAX)) ? 5'(TAG_MAX) : 5'(fcnt_reg);

    // Byte update and line judgment.
    always_comb begin
        pos_next     = pos_reg;
        xor_next     = xor_reg;
        star_next    = star_reg;
        hex_next     = hex_reg;
        hexovf_next  = hexovf_reg;
        hexstop_next = hexstop_reg;
        fcnt_next    = fcnt_reg;
        ttext_next   = ttext_reg;
        tlen_next    = tlen_reg;

        res               = '0;
        res.echo_byte     = b;
        res.byte_class    = CLS_PREFIX;
        res.line_done     = item.last_in_line;
        res.verdict       = VERD_OK_UNCHECKED;
        res.sentence_kind = KIND_OTHER;

        if (star_reg) begin
            // Accumulate checksum digits until the first non-digit.
            if (!hexstop_reg) begin
                if (!hex_ok) begin
                    hexstop_next = 1'b1;
                end else if (!hexovf_reg) begin
                    if (hex_reg[7:4] != 4'd0) begin
                        hexovf_next = 1'b1;
                        hex_next    = 8'hFF;
                    end else begin
                        hex_next = {hex_reg[3:0], hex_d};
                    end
                end
            end
            if (accepted) begin
                res.byte_class   = CLS_STAR;
                res.field_number = tag;
            end
        end else if (b == CHAR_STAR) begin
            star_next = 1'b1;
            if (accepted) begin
                res.byte_class   = CLS_STAR;
                res.field_number = tag;
            end
        end else begin
            if (pos_reg != 2'd0) xor_next = xor_reg ^ b;
            if (accepted) begin
                res.field_number = tag;
                if (b == CHAR_COMMA) begin
                    res.byte_class = CLS_COMMA;
                    if (fcnt_reg < FCW'(MAX_FIELDS)) fcnt_next = fcnt_reg + 1'b1;
                end else begin
                    res.byte_class = CLS_FIELD;
                    if (fcnt_reg == '0) begin
                        if (tlen_reg < 3'd3) begin
                            ttext_next = {ttext_reg[15:0], b};
                            tlen_next  = tlen_reg + 3'd1;
                        end else begin
                            tlen_next = 3'd4;
                        end
                    end
                end
            end
        end
        if (pos_reg != 2'd3) pos_next = pos_reg + 2'd1;

        res.computed_sum = xor_next;
        res.received_sum = hex_next;

        // Judge the line on its last byte.
        if (item.last_in_line) begin
            if (prefix_next != PFX_GP && prefix_next != PFX_P) begin
                res.verdict = VERD_BAD_PREFIX;
            end else begin
                if (star_next && (hexovf_next || hex_next != xor_next)) begin
                    res.verdict = VERD_MISMATCH;
                end else if (fcnt_next >= FCW'(MAX_FIELDS)) begin
                    res.verdict = VERD_TOO_MANY;
                end else begin
                    res.verdict = star_next ? VERD_OK_CHECKED : VERD_OK_UNCHECKED;
                end
                res.fields_seen = (seen_wide > (FCW+1)'(SEEN_MAX)) ?
                                  6'(SEEN_MAX) : 6'(seen_wide);
                if (res.verdict == VERD_OK_UNCHECKED || res.verdict == VERD_OK_CHECKED) begin
                    res.sentence_kind = kind;
                end
            end
        end
    end

    assign seen_wide = {1'b0, fcnt_next} + 1'b1;

    // Sentence type from the text of field zero.
    always_comb begin
        kind = KIND_OTHER;
        if (tlen_next == 3'd3) begin
            case (ttext_next)
                TYPE_RMC: kind = KIND_RMC;
                TYPE_GGA: kind = KIND_GGA;
                TYPE_GSV: kind = KIND_GSV;
                TYPE_GSA: kind = KIND_GSA;
                TYPE_XDR: kind = KIND_XDR;
                TYPE_CAL: kind = KIND_CAL;
                default:  kind = KIND_OTHER;
            endcase
        end
    end

    // Advance state on each byte; clear it after the last byte of a line.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_in_line)) begin
            pos_reg     <= 2'd0;
            prefix_reg  <= PFX_PENDING;
            xor_reg     <= 8'd0;
            star_reg    <= 1'b0;
            hex_reg     <= 8'd0;
            hexovf_reg  <= 1'b0;
            hexstop_reg <= 1'b0;
            fcnt_reg    <= '0;
            ttext_reg   <= 24'd0;
            tlen_reg    <= 3'd0;
        end else if (step) begin
            pos_reg     <= pos_next;
            prefix_reg  <= prefix_next;
            xor_reg     <= xor_next;
            star_reg    <= star_next;
            hex_reg     <= hex_next;
            hexovf_reg  <= hexovf_next;
            hexstop_reg <= hexstop_next;
            fcnt_reg    <= fcnt_next;
            ttext_reg   <= ttext_next;
            tlen_reg    <= tlen_next;
        end
    end

    assign result = res;

endmodule

/* hdl/nmsc_out_stage.sv */
// Result register of the sentence checker: holds one request for the receiver.
module nmsc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  nmsc_pkg::result_t result,
    output logic              out_valid,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import nmsc_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Fill on load, drop once the receiver takes the request.
    always_comb begin
        valid_next = valid_reg;
        if (load) valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) res_reg <= result;
    end

    assign out_valid = valid_reg;
    assign m_tvalid  = valid_reg;
    assign m_tlast   = res_reg.line_done;
    assign m_tuser   = res_reg.byte_class;
    assign m_tdata   = {7'd0, res_reg.received_sum, res_reg.computed_sum,
                        res_reg.fields_seen, res_reg.sentence_kind, res_reg.verdict,
                        res_reg.field_number, res_reg.echo_byte};

endmodule

/* hdl/nmea_sentence_checker.sv */
// Top level of the NMEA 0183 sentence checker.
//
// Input stream: one received line character per request on s_tdata, with
// s_tlast on the final character of the line. Output stream: one result per
// character, the character echoed with its class (m_tuser), field number and
// running checksums; on the result with m_tlast set the verdict, sentence
// kind and field count are valid, elsewhere they read zero.
// An accepted character waits in the input register while the parse
// logic works on it; its result shows on m_tvalid once the result
// register loads it, which happens once that register has room.
// Throughput is one character per cycle while the receiver keeps m_tready
// high. Reset empties both registers and clears the parse state; the next
// byte starts a new line. Parse state is also cleared after every last
// byte. When the receiver stalls, the result register holds its request
// and the input register, if it is empty, still takes one more character
// before s_tready drops.
module nmea_sentence_checker #(
    parameter int MAX_FIELDS = nmsc_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] line_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] echo_byte, [12:8] field_number,
                                   // [15:13] verdict, [18:16] sentence_kind,
                                   // [24:19] fields_seen, [32:25] computed_sum,
                                   // [40:33] received_sum, [47:41] zero
    output logic [1:0]  m_tuser,   // [1:0] byte_class
    output logic        m_tlast
);
    import nmsc_pkg::*;

    logic    item_valid;
    logic    out_valid;
    logic    advance;
    item_t   item;
    result_t result;

    // Move the held character into the result register when there is room.
    assign advance = item_valid && (!out_valid || m_tready);

    nmsc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    nmsc_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item),
        .result  (result)
    );

    nmsc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .result    (result),
        .out_valid (out_valid),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* hdl/nmsc_checker.sv */
// Port-level assertions of the sentence checker and their bind.
`include "assert_macros.svh"

module nmsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import nmsc_pkg::*;

    logic        stalled;
    logic [50:0] m_beat;
    logic [11:0] summary;
    logic [2:0]  verd;
    logic [2:0]  kind;
    logic        line_ok;
    logic        pfx_byte;
    logic [4:0]  field_num;

    // Slice the result fields out of the stream.
    assign stalled   = m_tvalid && !m_tready;
    assign m_beat    = {m_tdata, m_tuser, m_tlast};
    assign summary   = m_tdata[24:13];
    assign verd      = m_tdata[15:13];
    assign kind      = m_tdata[18:16];
    assign line_ok   = (verd == VERD_OK_UNCHECKED) || (verd == VERD_OK_CHECKED);
    assign pfx_byte  = (m_tuser == CLS_PREFIX);
    assign field_num = m_tdata[12:8];

    // A stalled result holds.
    `NMSC_ASSERT(a_hold, stalled |=> m_tvalid && $stable(m_beat), "stalled result changed")

    // Line summary only on the last character.
    `NMSC_ASSERT_OUT(a_summary_zero, m_tlast || summary == 12'd0, "summary outside line end")

    // Verdict codes stay within the defined set.
    `NMSC_ASSERT_OUT(a_verdict_range, verd <= VERD_TOO_MANY, "verdict out of range")

    // A failed line reports no sentence kind.
    `NMSC_ASSERT_OUT(a_kind_on_fail, line_ok || kind == KIND_OTHER, "kind on failed line")

    // Prefix bytes carry field number zero.
    `NMSC_ASSERT_OUT(a_prefix_field, !pfx_byte || field_num == 5'd0, "field number on prefix")

endmodule

bind nmea_sentence_checker nmsc_checker u_nmsc_checker (.*);
